// File: design/hsd_pkg.sv
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared types, widths, length limits and helper functions for the Hamming SEC decoder.
// ----------------------------------------------------------------------------
package hsd_pkg;

  localparam int unsigned MaxCodeBits = 64;
  localparam int unsigned CwWidth     = MaxCodeBits;
  localparam int unsigned LenWidth    = 7;
  localparam int unsigned DataWidth   = 57;
  localparam int unsigned CountWidth  = 6;
  localparam int unsigned SynWidth    = 6;

  localparam logic [LenWidth-1:0] MinLen = LenWidth'(3);
  localparam logic [LenWidth-1:0] MaxLen = LenWidth'(MaxCodeBits);

  typedef struct packed {
    logic [CwWidth-1:0]  codeword;
    logic [LenWidth-1:0] code_length;
  } in_item_t;

  typedef struct packed {
    logic [DataWidth-1:0]  data_value;
    logic [CountWidth-1:0] data_count;
    logic                  error_found;
    logic [SynWidth-1:0]   error_position;
    logic                  uncorrectable;
  } out_item_t;

  // Positions (one-based) covered by check bit bit_idx.
  function automatic logic [CwWidth-1:0] check_mask(input int unsigned bit_idx);
    logic [CwWidth-1:0] m;
    m = '0;
    for (int unsigned p = 1; p <= CwWidth; p++) begin
      m[p-1] = ((p >> bit_idx) & 1) != 0;
    end
    return m;
  endfunction

  // Data positions of a full-length word, first data bit at the MSB.
  function automatic logic [DataWidth-1:0] gather_data(input logic [CwWidth-1:0] word);
    logic [DataWidth-1:0] d;
    logic [6:0]           idx;
    d   = '0;
    idx = 7'(DataWidth);
    for (int unsigned p = 1; p <= CwWidth; p++) begin
      if ((p & (p - 1)) != 0) begin
        idx             = idx - 7'd1;
        d[idx[5:0]]     = word[p-1];
      end
    end
    return d;
  endfunction

endpackage

// File: design/hamming_sec_decoder.sv
// ----------------------------------------------------------------------------
// hamming_sec_decoder
// Single-error-correcting Hamming decoder for codewords of 3 to 64 bits.
// ----------------------------------------------------------------------------
// One codeword per item; bit 0 of the codeword is position 1 and bits at or
// above code_length are ignored (lengths below 3 act as 3, above 64 as 64).
// Check bit i covers every position whose number has bit i set and exists
// only while 2^i is below the length; odd_parity inverts every check bit.
// A nonzero syndrome names the bit to flip; a syndrome beyond the length
// sets uncorrectable and nothing is flipped. Data bits are the non-power-of-
// two positions in ascending order, first one most significant, right
// aligned in data_value. Throughput is one item per clock while out_ready_i
// does not stall the output. Between input accept and result valid lie an
// input register, then the syndrome tree, correction and data alignment
// shifter, then the result register. Both registers stall independently,
// so a new item is taken while a finished result waits. The configuration
// channel is always ready and must only be written while no item is in flight.
// ----------------------------------------------------------------------------
module hamming_sec_decoder
  import hsd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  // configuration write
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i,
  // input items
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  // result items
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic odd_parity_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odd_parity_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      odd_parity_q <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: each stage advances when its successor has room
  // --------------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic out_room;
  logic s1_room;

  assign out_room   = !out_valid_q || out_ready_i;
  assign s1_room    = !s1_valid_q || out_room;
  assign in_ready_o = s1_room;

  // --------------------------------------------------------------------------
  // Input stage: clamp the length and clear bits beyond it
  // --------------------------------------------------------------------------
  logic [LenWidth-1:0] len_clamped;
  logic [CwWidth-1:0]  word_masked;
  logic [CwWidth-1:0]  s1_word_q;
  logic [LenWidth-1:0] s1_len_q;

  always_comb begin
    priority if (in_data_i.code_length < MinLen) begin
      len_clamped = MinLen;
    end else if (in_data_i.code_length > MaxLen) begin
      len_clamped = MaxLen;
    end else begin
      len_clamped = in_data_i.code_length;
    end
    // shift by the full width yields zero, so a 64-bit length keeps all bits
    word_masked = in_data_i.codeword & ~({CwWidth{1'b1}} << len_clamped);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_room) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_room) begin
      s1_word_q <= word_masked;
      s1_len_q  <= len_clamped;
    end
  end

  // --------------------------------------------------------------------------
  // Decode: syndrome, correction, data alignment
  // --------------------------------------------------------------------------
  logic [SynWidth-1:0]   syn;
  logic                  beyond_len;
  logic [CwWidth-1:0]    flip_vec;
  logic [CwWidth-1:0]    word_fixed;
  logic [LenWidth-1:0]   pow2_count;
  logic [CountWidth-1:0] data_count;
  logic [CountWidth-1:0] align_shift;
  out_item_t             out_d;
  out_item_t             out_data_q;

  always_comb begin
    // check bit i exists only while 2^i lies below the length
    for (int unsigned i = 0; i < SynWidth; i++) begin
      if (LenWidth'(1 << i) < s1_len_q) begin
        syn[i] = (^(s1_word_q & check_mask(i))) ^ odd_parity_q;
      end else begin
        syn[i] = 1'b0;
      end
    end

    beyond_len = LenWidth'(syn) > s1_len_q;

    if ((syn != '0) && !beyond_len) begin
      flip_vec = CwWidth'(1) << (syn - SynWidth'(1));
    end else begin
      flip_vec = '0;
    end
    word_fixed = s1_word_q ^ flip_vec;

    // powers of two up to the length: floor(log2(len)) + 1
    priority if (s1_len_q >= LenWidth'(64)) begin
      pow2_count = LenWidth'(7);
    end else if (s1_len_q >= LenWidth'(32)) begin
      pow2_count = LenWidth'(6);
    end else if (s1_len_q >= LenWidth'(16)) begin
      pow2_count = LenWidth'(5);
    end else if (s1_len_q >= LenWidth'(8)) begin
      pow2_count = LenWidth'(4);
    end else if (s1_len_q >= LenWidth'(4)) begin
      pow2_count = LenWidth'(3);
    end else begin
      pow2_count = LenWidth'(2);
    end

    data_count  = CountWidth'(s1_len_q - pow2_count);
    align_shift = CountWidth'(DataWidth) - data_count;

    out_d.data_value     = gather_data(word_fixed) >> align_shift;
    out_d.data_count     = data_count;
    out_d.error_found    = syn != '0;
    out_d.error_position = syn;
    out_d.uncorrectable  = beyond_len;
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_room) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_room) begin
      out_data_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: design/hsd_checker.sv
// ----------------------------------------------------------------------------
// hsd_checker
// Port-level checks for the Hamming SEC decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hsd_checker
  import hsd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // error flag follows syndrome
  a_err_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.error_found == (out_data_o.error_position != '0))
    else $error("error_found disagrees with error_position");

  // uncorrectable syndrome lies beyond the length, hence beyond the data count
  a_uncorr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.uncorrectable |->
      out_data_o.error_found && (out_data_o.error_position > out_data_o.data_count))
    else $error("uncorrectable result inconsistent");

  // accepted item passes the input and result registers to the output when not stalled
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i |=> out_valid_o)
    else $error("accepted item did not reach the output");

endmodule

bind hamming_sec_decoder hsd_checker u_hsd_checker (.*);

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hamming_sec_decoder. A directed table covers the
// length limits, both ends of the field ranges, and single, parity-position,
// uncorrectable and power-of-two-length cases. Random phases then run mostly
// valid codewords with zero, one or two flipped bits under both parity modes.
// Every result item is compared with a hand-derived expectation or a local decode model.
// ----------------------------------------------------------------------------
module tb;
  import hsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Budget for the slowest legal run: about 900 items, each with the largest
  // random input gap and output stall, plus drains and one long output
  // hold. This is taken several times over.
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned LongHold    = 50;  // long output hold, in cycles
  localparam int unsigned LatencyPad  = 4;   // two-stage pipe plus margin
  localparam int          NumDirected = 22;

  typedef struct {
    logic [CwWidth-1:0]  cw;
    logic [LenWidth-1:0] len;
    bit                  typed;  // 1: exp holds the expected item as written
    out_item_t           exp;
  } stim_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic      cfg_data_i;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  out_item_t   pending_results[$];  // decoded items not yet seen at the output
  logic        odd_sel;             // local copy of the odd_parity register
  bit          idle_on;             // random idling allowed on both sides
  bit          long_hold_req;       // asks the output side for one long hold
  int unsigned fail_cnt;
  int unsigned cycle_cnt;

  // Directed table. Rows with typed = 1 carry a hand-derived expectation;
  // the others go through the decode model.
  stim_row_t dir_rows [NumDirected] = '{
    // all zeros, full length
    '{64'h0, 7'd64, 1'b1, '{57'h0, 6'd57, 1'b0, 6'd0, 1'b0}},
    // all ones, full length: every check group is even
    '{64'hFFFF_FFFF_FFFF_FFFF, 7'd64, 1'b1,
      '{57'h1FF_FFFF_FFFF_FFFF, 6'd57, 1'b0, 6'd0, 1'b0}},
    // shortest legal length
    '{64'h0, 7'd3, 1'b1, '{57'h0, 6'd1, 1'b0, 6'd0, 1'b0}},
    // lengths below the minimum clamp to 3
    '{64'h0, 7'd0, 1'b1, '{57'h0, 6'd1, 1'b0, 6'd0, 1'b0}},
    '{64'h0, 7'd2, 1'b1, '{57'h0, 6'd1, 1'b0, 6'd0, 1'b0}},
    // lengths above the maximum clamp to 64
    '{64'h0, 7'd127, 1'b1, '{57'h0, 6'd57, 1'b0, 6'd0, 1'b0}},
    '{64'h0, 7'd65, 1'b1, '{57'h0, 6'd57, 1'b0, 6'd0, 1'b0}},
    // power-of-two length: last position is neither checked nor data
    '{64'h8, 7'd4, 1'b1, '{57'h0, 6'd1, 1'b0, 6'd0, 1'b0}},
    // single error on a data position, fixed
    '{64'h10, 7'd7, 1'b1, '{57'h0, 6'd4, 1'b1, 6'd5, 1'b0}},
    // single error on a parity position, data untouched
    '{64'h1, 7'd7, 1'b1, '{57'h0, 6'd4, 1'b1, 6'd1, 1'b0}},
    // syndrome beyond the length: flagged, nothing flipped
    '{64'hA, 7'd5, 1'b1, '{57'h0, 6'd2, 1'b1, 6'd6, 1'b1}},
    // bits above the length are ignored
    '{64'hFFFF_FFFF_FFFF_FFF8, 7'd3, 1'b1, '{57'h0, 6'd1, 1'b0, 6'd0, 1'b0}},
    // top bit is position 64, outside every check group at full length
    '{64'h8000_0000_0000_0000, 7'd64, 1'b1, '{57'h0, 6'd57, 1'b0, 6'd0, 1'b0}},
    // position 63 gives the largest syndrome
    '{64'h4000_0000_0000_0000, 7'd64, 1'b1, '{57'h0, 6'd57, 1'b1, 6'd63, 1'b0}},
    '{64'hFFFF_FFFF_FFFF_FFFF, 7'd63, 1'b0, '0},
    '{64'h5555_5555_5555_5555, 7'd64, 1'b0, '0},
    '{64'hDEAD_BEEF_0123_4567, 7'd40, 1'b0, '0},
    '{64'h7, 7'd3, 1'b1, '{57'h1, 6'd1, 1'b0, 6'd0, 1'b0}},
    '{64'h1234_5678_9ABC_DEF0, 7'd33, 1'b0, '0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b1,
      '{57'h1FF_FFFF_FFFF_FFFF, 6'd57, 1'b0, 6'd0, 1'b0}},
    // error on the last position of the word
    '{64'h20, 7'd6, 1'b1, '{57'h0, 6'd3, 1'b1, 6'd6, 1'b0}},
    '{64'hA5A5_0F0F_3C3C_9696, 7'd17, 1'b0, '0}
  };

  hamming_sec_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Decode model: clamp the length, build the syndrome over the check
  // groups that exist, flip the named bit if it is inside the word, then
  // pack the non-power-of-two positions with the first one at the top.
  function automatic out_item_t decode_codeword(input logic [CwWidth-1:0]  word_in,
                                                input logic [LenWidth-1:0] len_raw,
                                                input logic                odd);
    out_item_t             res;
    logic [CwWidth-1:0]    word;
    logic [DataWidth-1:0]  data;
    logic [SynWidth-1:0]   syn;
    logic                  acc;
    logic                  bad;
    int                    len;
    int                    cnt;
    word = word_in;
    len  = len_raw;
    if (len < MinLen) len = MinLen;
    if (len > MaxLen) len = MaxLen;
    syn = '0;
    for (int i = 0; i < SynWidth; i++) begin
      if ((1 << i) < len) begin
        acc = odd;
        for (int p = 1; p <= len; p++) begin
          if (p[i]) acc = acc ^ word[p-1];
        end
        syn[i] = acc;
      end
    end
    bad = syn > len;
    if (syn != 0 && !bad) word[syn-1] = ~word[syn-1];
    data = '0;
    cnt  = 0;
    for (int p = 1; p <= len; p++) begin
      if ((p & (p - 1)) != 0) begin
        data = {data[DataWidth-2:0], word[p-1]};
        cnt++;
      end
    end
    res.data_value     = data;
    res.data_count     = CountWidth'(cnt);
    res.error_found    = syn != 0;
    res.error_position = syn;
    res.uncorrectable  = bad;
    return res;
  endfunction

  // Offer one item, optionally after a random gap; returns at the edge that
  // took it, with nothing scheduled on in_valid_i for that edge yet.
  task automatic send_item(input logic [CwWidth-1:0]  cw,
                           input logic [LenWidth-1:0] len,
                           input out_item_t           want);
    if (idle_on && $urandom_range(0, 99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{codeword: cw, code_length: len};
    do @(posedge clk_i); while (!in_ready_o);
    pending_results = {pending_results, want};
  endtask

  // Stop offering, wait for every outstanding result, then let the pipe
  // settle. Always advances at least one edge.
  task automatic flush_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (LatencyPad) @(posedge clk_i);
  endtask

  task automatic write_parity_mode(input logic odd);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= odd;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    odd_sel = odd;
  endtask

  // Random items. Most are valid codewords (parity repaired via the model)
  // with zero, one or two injected flips; the rest are raw noise. Uncorrectable
  // cases come from the noise and from the double flips.
  task automatic run_random(input int n, input bit allow_idle, input bit with_pressure);
    logic [CwWidth-1:0]  cw;
    logic [LenWidth-1:0] len;
    out_item_t           probe;
    int                  eff;
    int                  pick;
    int                  pos;
    for (int k = 0; k < n; k++) begin
      // idle in two chunks of 60 items out of three, full speed in the third
      idle_on = allow_idle && ((k / 60) % 3 != 2);
      // output side holds off while input keeps coming: pipe fills, input stalls
      if (with_pressure && k == 100) long_hold_req = 1'b1;
      // input side pauses until the pipe is empty
      if (with_pressure && k == 200) flush_results();

      pick = $urandom_range(0, 99);
      if (pick < 8) len = LenWidth'($urandom_range(0, 127));
      else if (pick < 35) len = LenWidth'(MaxCodeBits);
      else len = LenWidth'($urandom_range(3, MaxCodeBits));
      eff = (len < MinLen) ? MinLen : (len > MaxLen) ? MaxLen : len;

      cw   = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 90) begin
        probe = decode_codeword(cw, len, odd_sel);
        if (probe.error_found && !probe.uncorrectable) begin
          pos     = probe.error_position - 1;
          cw[pos] = ~cw[pos];
        end
      end
      if (pick >= 40 && pick < 90) begin
        pos     = $urandom_range(0, eff - 1);
        cw[pos] = ~cw[pos];
      end
      if (pick >= 80 && pick < 90) begin
        pos     = $urandom_range(0, eff - 1);
        cw[pos] = ~cw[pos];
      end
      send_item(cw, len, decode_codeword(cw, len, odd_sel));
    end
  endtask

  // Output side: ready by default, random stall bursts while idling is on,
  // and one long hold on request.
  initial begin : out_side
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 99) < 15) begin
        gap = $urandom_range(1, 15);
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Result checker: every accepted output item against the oldest prediction.
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result item with no pending expectation");
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.data_value !== want.data_value) begin
          $error("data_value: expected %h, got %h", want.data_value, out_data_o.data_value);
          fail_cnt++;
        end
        if (out_data_o.data_count !== want.data_count) begin
          $error("data_count: expected %0d, got %0d", want.data_count, out_data_o.data_count);
          fail_cnt++;
        end
        if (out_data_o.error_found !== want.error_found) begin
          $error("error_found: expected %b, got %b", want.error_found,
                 out_data_o.error_found);
          fail_cnt++;
        end
        if (out_data_o.error_position !== want.error_position) begin
          $error("error_position: expected %0d, got %0d", want.error_position,
                 out_data_o.error_position);
          fail_cnt++;
        end
        if (out_data_o.uncorrectable !== want.uncorrectable) begin
          $error("uncorrectable: expected %b, got %b", want.uncorrectable,
                 out_data_o.uncorrectable);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAIL hamming_sec_decoder");
      $finish;
    end
  end

  initial begin : main_seq
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_ready_i   = 1'b0;
    odd_sel       = 1'b0;
    idle_on       = 1'b0;
    long_hold_req = 1'b0;
    fail_cnt      = 0;
    cycle_cnt     = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, even parity
    write_parity_mode(1'b0);
    idle_on = 1'b1;
    foreach (dir_rows[r]) begin
      send_item(dir_rows[r].cw, dir_rows[r].len,
                dir_rows[r].typed ? dir_rows[r].exp
                                  : decode_codeword(dir_rows[r].cw, dir_rows[r].len, odd_sel));
    end
    flush_results();

    // odd parity, with the long output hold and the input pause
    write_parity_mode(1'b1);
    run_random(300, 1'b1, 1'b1);
    flush_results();

    // back to even parity
    write_parity_mode(1'b0);
    run_random(300, 1'b1, 1'b0);
    flush_results();

    // last part: odd parity, no idling on either side
    write_parity_mode(1'b1);
    run_random(250, 1'b0, 1'b0);
    flush_results();

    if (fail_cnt == 0) begin
      $display("PASS hamming_sec_decoder");
    end else begin
      $display("FAIL hamming_sec_decoder");
    end
    $finish;
  end

endmodule
